// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the energy onset detector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define EOD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EOD_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define EOD_ASSERT(name, clk, rst_n, prop, msg)
`define EOD_ASSERT_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/eod_pkg.sv =====
// ----------------------------------------------------------------------------
// Energy onset detector package
// Widths, reset values, register indexes and item types of the detector.
// ----------------------------------------------------------------------------
package eod_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int SQ_W       = 31;
  localparam int SUM_W      = 41;
  localparam int PROD_W     = 47;
  localparam int FRAME_W    = 32;
  localparam int WIN_W      = 10;
  localparam int HOP_W      = 9;
  localparam int SKIP_W     = 16;
  localparam int CHAN_W     = 2;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 41;

  localparam int MAX_WINDOW_DEF = 512;
  localparam int CHANNELS_DEF   = 2;

  localparam logic [WIN_W-1:0]  WIN_LEN_RST   = WIN_W'(240);
  localparam logic [SKIP_W-1:0] SKIP_LEN_RST  = SKIP_W'(2400);
  localparam logic [SUM_W-1:0]  THRESHOLD_RST = SUM_W'(206158430);
  localparam logic [CHAN_W-1:0] CHAN_CNT_RST  = CHAN_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN    = 4'd0,
    CFG_SKIP_LEN      = 4'd1,
    CFG_THRESHOLD     = 4'd2,
    CFG_CHANNEL_COUNT = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
    logic                       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] onset_position;
    logic [SUM_W-1:0]   onset_energy;
  } out_item_t;

  typedef struct packed {
    logic [WIN_W-1:0]  win_len;
    logic [HOP_W-1:0]  hop;
    logic [SKIP_W-1:0] skip;
    logic [SUM_W-1:0]  threshold;
    logic              use_right;
  } cfg_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [SUM_W-1:0]   energy;
    logic               last;
  } win_t;

endpackage

// ===== rtl/eod_lane.sv =====
// ----------------------------------------------------------------------------
// Energy onset detector lane
// Squares one channel sample of an item and registers the product.
// ----------------------------------------------------------------------------
module eod_lane (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic signed [eod_pkg::SAMPLE_W-1:0] sample_i,
  output logic        [eod_pkg::SQ_W-1:0]     sq_o
);
  import eod_pkg::*;

  logic signed [2*SAMPLE_W-1:0] prod;
  logic        [SQ_W-1:0]       sq_q;

  assign prod = (2*SAMPLE_W)'(sample_i) * (2*SAMPLE_W)'(sample_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sq_q <= prod[SQ_W-1:0];
    end
  end

  assign sq_o = sq_q;

endmodule

// ===== rtl/eod_window.sv =====
// ----------------------------------------------------------------------------
// Energy onset detector window
// Merges the lane squares, keeps the square delay line and the sliding sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eod_window #(
  parameter int MAX_WINDOW = eod_pkg::MAX_WINDOW_DEF,
  parameter int LANES      = eod_pkg::CHANNELS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  eod_pkg::cfg_t            cfg_i,
  input  logic                     in_acc_i,
  input  logic                     eob_i,
  input  logic [eod_pkg::SQ_W-1:0] lane_sq_i [LANES],
  input  logic                     s2_go_i,
  output logic                     s1_valid_o,
  output logic                     load_o,
  output eod_pkg::win_t            win_o
);
  import eod_pkg::*;

  localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW     = ((AW > WIN_W) ? AW : WIN_W) + 1;
  localparam int LSUM_W = SQ_W + 1;

  logic [SQ_W-1:0]    mem [MAX_WINDOW];
  logic [SQ_W-1:0]    rdata_q;
  logic [FRAME_W-1:0] frame_q, frame_d, frame_inc;
  logic [AW-1:0]      slot_q, slot_d, old_slot;
  logic               v1_q, v1_d;
  logic [FRAME_W-1:0] fi1_q;
  logic [AW-1:0]      slot1_q;
  logic               sub1_q, eob1_q;
  logic [SUM_W-1:0]   rs_q, rs_d, rs_next;
  logic [SW-1:0]      slot_ext, win_ext, old_ext;
  logic [LSUM_W-1:0]  lane_sum;
  logic [SQ_W-1:0]    sq_sat;
  logic               move;

  assign move = v1_q && s2_go_i;

  always_comb begin
    slot_ext = SW'(slot_q);
    win_ext  = SW'(cfg_i.win_len);
    if (slot_ext >= win_ext) begin
      old_ext = slot_ext - win_ext;
    end else begin
      old_ext = slot_ext + SW'(MAX_WINDOW) - win_ext;
    end
    old_slot = old_ext[AW-1:0];
  end

  always_comb begin
    frame_inc = frame_q + FRAME_W'(1);
    frame_d   = frame_q;
    slot_d    = slot_q;
    if (in_acc_i) begin
      if (eob_i) begin
        frame_d = '0;
        slot_d  = '0;
      end else begin
        frame_d = frame_inc;
        if (frame_inc == '0 || slot_q == AW'(MAX_WINDOW - 1)) begin
          slot_d = '0;
        end else begin
          slot_d = slot_q + AW'(1);
        end
      end
    end
  end

  always_comb begin
    lane_sum = '0;
    for (int k = 0; k < LANES; k++) begin
      if (k == 0 || cfg_i.use_right) begin
        lane_sum = lane_sum + LSUM_W'(lane_sq_i[k]);
      end
    end
    sq_sat  = lane_sum[LSUM_W-1] ? '1 : lane_sum[SQ_W-1:0];
    rs_next = rs_q + SUM_W'(sq_sat) - (sub1_q ? SUM_W'(rdata_q) : '0);
  end

  always_comb begin
    rs_d = rs_q;
    v1_d = v1_q;
    if (move) begin
      rs_d = eob1_q ? '0 : rs_next;
      v1_d = 1'b0;
    end
    if (in_acc_i) begin
      v1_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
      slot_q  <= '0;
      v1_q    <= 1'b0;
      rs_q    <= '0;
    end else begin
      frame_q <= frame_d;
      slot_q  <= slot_d;
      v1_q    <= v1_d;
      rs_q    <= rs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      fi1_q   <= frame_q;
      slot1_q <= slot_q;
      sub1_q  <= (frame_q >= FRAME_W'(cfg_i.win_len));
      eob1_q  <= eob_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && !eob1_q) begin
      mem[slot1_q] <= sq_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      rdata_q <= mem[old_slot];
    end
  end

  assign s1_valid_o = v1_q;
  assign load_o     = move;
  assign win_o      = '{frame: fi1_q, energy: rs_next, last: eob1_q};

  `EOD_ASSERT_NEVER(a_slot_range, clk_i, rst_ni, slot_q > AW'(MAX_WINDOW - 1), "slot out of range")
  `EOD_ASSERT(a_sum_cleared, clk_i, rst_ni, (move && eob1_q) |=> (rs_q == '0), "sum not cleared")
  `EOD_ASSERT_NEVER(a_rw_clash, clk_i, rst_ni, in_acc_i && move && !eob1_q && (old_slot == slot1_q), "delay line read hits the slot being written")

endmodule

// ===== rtl/eod_judge.sv =====
// ----------------------------------------------------------------------------
// Energy onset detector judge
// Judges completed windows against the threshold and the previous window.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eod_judge (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  eod_pkg::cfg_t      cfg_i,
  input  logic               load_i,
  input  eod_pkg::win_t      win_i,
  output logic               s2_go_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output eod_pkg::out_item_t out_item_o
);
  import eod_pkg::*;

  logic               v2_q, v2_d;
  win_t               item_q;
  logic [FRAME_W-1:0] nws_q, nws_d, win_end;
  logic [PROD_W-1:0]  prev36_q, prev36_d, e_ext, e25, e36;
  logic               ov_q, ov_d;
  out_item_t          out_q;
  logic               judge, fire, out_free, s2_go, leave;

  always_comb begin
    e_ext    = PROD_W'(item_q.energy);
    e25      = (e_ext << 4) + (e_ext << 3) + e_ext;
    e36      = (e_ext << 5) + (e_ext << 2);
    win_end  = nws_q + FRAME_W'(cfg_i.win_len) - FRAME_W'(1);
    judge    = v2_q && !item_q.last && (item_q.frame == win_end);
    fire     = judge && (item_q.energy > cfg_i.threshold) && (e25 > prev36_q);
    out_free = !ov_q || out_ready_i;
    s2_go    = !v2_q || !fire || out_free;
    leave    = v2_q && s2_go;
  end

  always_comb begin
    nws_d    = nws_q;
    prev36_d = prev36_q;
    v2_d     = v2_q;
    ov_d     = ov_q && !out_ready_i;
    if (leave) begin
      v2_d = 1'b0;
      if (item_q.last) begin
        nws_d    = '0;
        prev36_d = '0;
      end else if (judge) begin
        prev36_d = e36;
        nws_d    = nws_q + FRAME_W'(cfg_i.hop) + (fire ? FRAME_W'(cfg_i.skip) : '0);
      end
      if (fire) begin
        ov_d = 1'b1;
      end
    end
    if (load_i) begin
      v2_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q     <= 1'b0;
      nws_q    <= '0;
      prev36_q <= '0;
      ov_q     <= 1'b0;
    end else begin
      v2_q     <= v2_d;
      nws_q    <= nws_d;
      prev36_q <= prev36_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= win_i;
    end
    if (leave && fire) begin
      out_q <= '{onset_position: nws_q, onset_energy: item_q.energy};
    end
  end

  assign s2_go_o     = s2_go;
  assign out_valid_o = ov_q;
  assign out_item_o  = out_q;

  `EOD_ASSERT(a_state_cleared, clk_i, rst_ni, (leave && item_q.last) |=> (nws_q == '0 && prev36_q == '0), "state not cleared")
  `EOD_ASSERT(a_onset_shown, clk_i, rst_ni, (leave && fire) |=> ov_q, "onset not presented")

endmodule

// ===== rtl/energy_onset_detector.sv =====
// ----------------------------------------------------------------------------
// Energy onset detector
// Sliding sum of squared frame samples with onset detection per window.
//
//   Port group   Direction   Handshake                 Payload
//   in           input       in_valid_i / in_ready_o   in_item_i (in_item_t)
//   out          output      out_valid_o / out_ready_i out_item_o (out_item_t)
//   cfg          input       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One item per cycle sustained while no pending onset stalls the judge; the
// delay line has one read and one write port, and an item moves through the
// lane and window stage, the judge stage and the output register.
// Reset clears counters and sums at once; the delay line needs no clearing.
// A stalled result blocks input only when the item in the judge has an onset.
// ----------------------------------------------------------------------------
module energy_onset_detector #(
  parameter int MAX_WINDOW = eod_pkg::MAX_WINDOW_DEF,
  parameter int CHANNELS   = eod_pkg::CHANNELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  eod_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output eod_pkg::out_item_t               out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [eod_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [eod_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import eod_pkg::*;

  localparam int LANES = (CHANNELS >= 2) ? 2 : 1;

  logic [WIN_W-1:0]  win_len_q;
  logic [SKIP_W-1:0] skip_len_q;
  logic [SUM_W-1:0]  threshold_q;
  logic [CHAN_W-1:0] chan_cnt_q;
  logic [WIN_W-1:0]  win_eff;
  cfg_t              cfg;

  logic                       in_acc, s1_valid, s2_go, load;
  logic signed [SAMPLE_W-1:0] lane_sample [LANES];
  logic [SQ_W-1:0]            lane_sq [LANES];
  win_t                       win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q   <= WIN_LEN_RST;
      skip_len_q  <= SKIP_LEN_RST;
      threshold_q <= THRESHOLD_RST;
      chan_cnt_q  <= CHAN_CNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_WINDOW_LEN:    win_len_q   <= cfg_data_i[WIN_W-1:0];
        CFG_SKIP_LEN:      skip_len_q  <= cfg_data_i[SKIP_W-1:0];
        CFG_THRESHOLD:     threshold_q <= cfg_data_i[SUM_W-1:0];
        CFG_CHANNEL_COUNT: chan_cnt_q  <= cfg_data_i[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (win_len_q < WIN_W'(2)) begin
      win_eff = WIN_W'(2);
    end else if (32'(win_len_q) > MAX_WINDOW) begin
      win_eff = WIN_W'(MAX_WINDOW);
    end else begin
      win_eff = win_len_q;
    end
    cfg.win_len   = win_eff;
    cfg.hop       = win_eff[WIN_W-1:1];
    cfg.skip      = (skip_len_q == '0) ? SKIP_W'(1) : skip_len_q;
    cfg.threshold = threshold_q;
    cfg.use_right = (LANES >= 2) && (chan_cnt_q >= CHAN_W'(2));
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !s1_valid || s2_go;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_sample[k] = (k == 0) ? in_item_i.sample_left : in_item_i.sample_right;
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    eod_lane u_lane (
      .clk_i    (clk_i),
      .load_i   (in_acc),
      .sample_i (lane_sample[g]),
      .sq_o     (lane_sq[g])
    );
  end

  eod_window #(
    .MAX_WINDOW (MAX_WINDOW),
    .LANES      (LANES)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_acc_i   (in_acc),
    .eob_i      (in_item_i.end_of_buffer),
    .lane_sq_i  (lane_sq),
    .s2_go_i    (s2_go),
    .s1_valid_o (s1_valid),
    .load_o     (load),
    .win_o      (win)
  );

  eod_judge u_judge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .load_i      (load),
    .win_i       (win),
    .s2_go_o     (s2_go),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
